/* src/arw_pkg.sv */
// Shared types and constants for the anti-replay window block.
// No dependencies; imported by arw_bitmap_store and anti_replay_window.
`timescale 1ns / 1ps

package arw_pkg;

    localparam int WORD_BITS        = 64;
    localparam int LANE_W           = 6;      // bit index within a word
    localparam int WINDOW_BITS_DEF  = 1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_BEHIND,
        ST_RD,
        ST_WR,
        ST_DONE
    } t_state;

    // Bitmap store control, one request per cycle at most
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr_all;
    } t_mem_ctl;

endpackage

/* src/arw_bitmap_store.sv */
// Seen-bitmap word store: memory with registered read and per-word valid flags.
// Depends on arw_pkg. An invalid word reads as zero; clr_all drops every flag.
`timescale 1ns / 1ps

module arw_bitmap_store
    import arw_pkg::*;
#(
    parameter int AW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_ctl             i_ctl,
    input  logic [AW-1:0]        i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    output logic [WORD_BITS-1:0] o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr_all) begin
            r_valid <= '0;
        end else if (i_ctl.wr) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata  <= r_mem[i_addr];
            r_rvalid <= r_valid[i_addr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

/* src/anti_replay_window.sv */
// Sliding-window anti-replay check: top level, sequencer and shared subtractor.
// Depends on arw_pkg and arw_bitmap_store.
`timescale 1ns / 1ps

// Channel   | Dir | Signals                        | Item
// ----------+-----+--------------------------------+------------------------------
// seq in    | in  | i_s_tvalid/o_s_tready/i_s_tdata | seq_number[63:0]
// result    | out | o_m_tvalid/i_m_tready/o_m_tdata | accepted[0], zeros [7:1]
//
// Steps: one item is worked on at a time; o_s_tready is high only while idle.
//   Too old: compare, behind, done. Inside window: compare, behind, read, write,
//   done. Newer number: compare, then a read and a write on the single-port store
//   for every 64-bit word the slide touches (1 up to WINDOW_BITS/64 + 1), then done.
// Reset: synchronous, active low; clears the sequencer, started flag and the
//   store's per-word valid flags, so no clearing pass is needed.
// Stalls: the result register holds while i_m_tready is low; the next item is
//   taken meanwhile and waits in its final step until the register frees.

module anti_replay_window
    import arw_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] seq_number
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] accepted, [7:1] zero
);

    localparam int WORDS = WINDOW_BITS / WORD_BITS;
    // Ring of 2**AW words; window positions map by the low bits of the number
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_state               r_state, n_state;
    logic [63:0]          r_seq, n_seq;
    logic [63:0]          r_high, n_high;
    logic                 r_started, n_started;
    logic [AW-1:0]        r_addr, n_addr;
    logic [AW:0]          r_cnt, n_cnt;       // words left after this one
    logic                 r_first, n_first;   // first word of a slide
    logic                 r_adv, n_adv;       // window moves forward
    logic                 r_acc, n_acc;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_acc, n_out_acc;

    // Shared 64-bit subtract and window compare
    logic [63:0]          sub_a, sub_b;
    logic [64:0]          sub_res;
    logic                 sub_borrow;
    logic                 sub_ge_win;

    t_mem_ctl             mem_ctl;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [WORD_BITS-1:0] seq_bit;
    logic [WORD_BITS-1:0] clr_mask;
    logic                 last_word;
    logic                 hit;
    logic                 out_free;

    always_comb begin
        if (r_state == ST_BEHIND) begin
            sub_a = r_high;
            sub_b = r_seq;
        end else begin
            sub_a = r_seq;
            sub_b = r_high;
        end
        sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
        sub_borrow = sub_res[64];
        sub_ge_win = sub_res[63:0] >= 64'(WINDOW_BITS);
    end

    // Bits of the current word that leave the window on a slide:
    // above the old highest in the first word, up to the new number in the last.
    always_comb begin
        last_word = (r_cnt == '0);
        seq_bit   = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_seq[LANE_W-1:0];
        for (int i = 0; i < WORD_BITS; i++) begin
            clr_mask[i] = (!r_first || (LANE_W'(i) > r_high[LANE_W-1:0]))
                       && (!last_word || (LANE_W'(i) <= r_seq[LANE_W-1:0]));
        end
        hit      = (mem_rdata & seq_bit) != '0;
        out_free = !r_out_valid || i_m_tready;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!r_started || (!sub_borrow && sub_res[63:0] != '0)) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_BEHIND;
                end
            end
            ST_BEHIND: begin
                n_state = sub_ge_win ? ST_DONE : ST_RD;
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                n_state = (r_adv && !last_word) ? ST_RD : ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_seq       = r_seq;
        n_high      = r_high;
        n_started   = r_started;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_adv       = r_adv;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_acc   = r_out_acc;
        mem_ctl     = '0;
        mem_wdata   = '0;
        o_s_tready  = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                n_seq      = i_s_tdata;
            end
            ST_CMP: begin
                n_adv   = 1'b1;
                n_acc   = 1'b1;
                n_first = 1'b0;
                n_cnt   = '0;
                n_addr  = r_seq[LANE_W +: AW];
                if (!r_started || (!sub_borrow && sub_res[63:0] != '0 && sub_ge_win)) begin
                    // first number or a jump of a whole window: start empty
                    mem_ctl.clr_all = 1'b1;
                end else if (!sub_borrow && sub_res[63:0] != '0) begin
                    // slide: sweep the words from the old highest to the new number
                    n_first = 1'b1;
                    n_addr  = r_high[LANE_W +: AW];
                    n_cnt   = r_seq[LANE_W +: AW+1] - r_high[LANE_W +: AW+1];
                end
            end
            ST_BEHIND: begin
                n_adv   = 1'b0;
                n_first = 1'b0;
                n_cnt   = '0;
                n_addr  = r_seq[LANE_W +: AW];
                n_acc   = 1'b0;
            end
            ST_RD: begin
                mem_ctl.rd = 1'b1;
            end
            ST_WR: begin
                if (r_adv) begin
                    mem_ctl.wr = 1'b1;
                    mem_wdata  = (mem_rdata & ~clr_mask) | (last_word ? seq_bit : '0);
                    n_addr     = r_addr + 1'b1;
                    n_cnt      = r_cnt - 1'b1;
                    n_first    = 1'b0;
                end else begin
                    n_acc = !hit;
                    if (!hit) begin
                        mem_ctl.wr = 1'b1;
                        mem_wdata  = mem_rdata | seq_bit;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_acc;
                    if (r_adv) begin
                        n_high    = r_seq;
                        n_started = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
            r_adv       <= 1'b0;
            r_acc       <= 1'b0;
            r_first     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
            r_adv       <= n_adv;
            r_acc       <= n_acc;
            r_first     <= n_first;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_addr    <= n_addr;
        r_out_acc <= n_out_acc;
    end

    arw_bitmap_store #(
        .AW(AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_addr  (r_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_acc};

    // An accepted item always starts with the compare step
    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_CMP))
        else $error("accepted item did not enter compare");

    // A slide with words left goes back for the next word
    a_sweep_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR && r_adv && r_cnt != '0) |=> (r_state == ST_RD))
        else $error("slide sweep ended early");

    // A rejected number leaves the window position untouched
    a_reject_keeps_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free && !r_acc) |=> ($stable(r_high) && $stable(r_started)))
        else $error("rejected number moved the window");

    // A forward move is always posted as accepted
    a_reject_not_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_adv) |-> r_acc)
        else $error("forward move posted as rejected");

endmodule
